/* hdl/ilws_pkg.sv */
// Package for the indexed list block: sizes, action and status codes, cell
// commands, result record and the capacity growth and shrink functions.
// Depends on nothing.
`default_nettype none

package ilws_pkg;

    localparam int DEPTH        = 64;
    localparam int MIN_CAPACITY = 8;
    localparam int CELL_WIDTH   = 64;

    localparam int ACT_W  = 3;
    localparam int IDX_FW = 7;
    localparam int VAL_W  = 64;
    localparam int LEN_FW = 7;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > IDX_FW) ? CNT_W : IDX_FW;
    localparam int WK_W   = CMP_W + 1;
    localparam int STEPS  = $clog2(DEPTH) + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_SET    = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_DELETE = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_STEP   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t             cmd;
        logic [CMP_W-1:0]      pos;
        logic [CELL_WIDTH-1:0] data;
    } cell_ctl_t;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [LEN_FW-1:0] list_length;
        logic [LEN_FW-1:0] capacity;
        status_t           status;
        logic              has_more;
        logic [IDX_FW-1:0] next_index;
    } result_t;

    function automatic logic [WK_W-1:0] grow_cap(input logic [WK_W-1:0] cap,
                                                 input logic [WK_W-1:0] need);
        logic [WK_W-1:0] size;
        size = (cap != '0) ? cap : WK_W'(MIN_CAPACITY);
        for (int k = 0; k < STEPS; k++)
        begin
            if (size < need && size < WK_W'(DEPTH))
            begin
                size = size << 1;
            end
        end
        if (size > WK_W'(DEPTH))
        begin
            size = WK_W'(DEPTH);
        end
        if (need <= cap)
        begin
            size = cap;
        end
        return size;
    endfunction

    function automatic logic [WK_W-1:0] shrink_cap(input logic [WK_W-1:0] cap,
                                                   input logic [WK_W-1:0] len);
        logic [WK_W-1:0] size;
        size = cap >> 1;
        for (int k = 0; k < STEPS; k++)
        begin
            if ((size >> 2) >= len && size > WK_W'(MIN_CAPACITY))
            begin
                size = size >> 1;
            end
        end
        if (size < WK_W'(MIN_CAPACITY))
        begin
            size = WK_W'(MIN_CAPACITY);
        end
        if (cap <= WK_W'(MIN_CAPACITY) || (cap >> 2) < len)
        begin
            size = cap;
        end
        return size;
    endfunction

endpackage

`default_nettype wire

/* hdl/ilws_if.sv */
// Handshake channels of the indexed list block: the item channel and the
// result channel. Depends on ilws_pkg.
`default_nettype none

interface ilws_item_if;
    import ilws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [IDX_FW-1:0]    index;
    logic [VAL_W-1:0]     value;

    modport source (output valid, output action, output index, output value,
                    input ready);
    modport sink   (input valid, input action, input index, input value,
                    output ready);
endinterface

interface ilws_result_if;
    import ilws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VAL_W-1:0]     read_value;
    logic [LEN_FW-1:0]    list_length;
    logic [LEN_FW-1:0]    capacity;
    status_t              status;
    logic                 has_more;
    logic [IDX_FW-1:0]    next_index;

    modport source (output valid, output read_value, output list_length,
                    output capacity, output status, output has_more,
                    output next_index, input ready);
    modport sink   (input valid, input read_value, input list_length,
                    input capacity, input status, input has_more,
                    input next_index, output ready);
endinterface

`default_nettype wire

/* hdl/indexed_list_with_shift.sv */
// Indexed list top level: item handshake, control, the row of element
// cells and the result register. Depends on ilws_pkg, ilws_if, ilws_cell,
// ilws_ctrl.
//
// Ordered list of up to DEPTH elements held in a row of cells, one element
// per cell. Every action (get, set, append, insert, delete, clear, iteration
// step) acts in the clock that accepts it: insert and delete move all later
// cells by one place in that same clock, each taking its neighbor's value.
// The block takes one item per cycle while the output register is empty or
// its result is being consumed; the result appears in the output register
// in the cycle after the item is accepted. Each result carries the length
// and the tracked capacity after the action; failed actions report a status
// and leave the list as it was. Element contents need no clearing after reset.
`default_nettype none

module indexed_list_with_shift (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ilws_item_if.sink       item_in,
    ilws_result_if.source   result_out
);
    import ilws_pkg::*;

    logic                  fire;
    cell_ctl_t             ctl;
    result_t               res;
    logic                  rd_en;
    logic [CNT_W-1:0]      cur_len;
    logic [CELL_WIDTH-1:0] cell_val [DEPTH];
    logic [CELL_WIDTH-1:0] cell_tap [DEPTH];
    logic [CELL_WIDTH-1:0] rd_data;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               res_reg;
    result_t               res_next;

    assign item_in.ready = !out_valid_reg || result_out.ready;
    assign fire          = item_in.valid && item_in.ready;

    ilws_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .action  (item_in.action),
        .index   (item_in.index),
        .value   (item_in.value),
        .ctl     (ctl),
        .res     (res),
        .rd_en   (rd_en),
        .cur_len (cur_len)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ilws_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .my_pos    (CMP_W'(i)),
            .rd_pos    (CMP_W'(item_in.index)),
            .left_val  (cell_val[(i == 0) ? 0 : i - 1]),
            .right_val (cell_val[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
            .val       (cell_val[i]),
            .tap       (cell_tap[i])
        );
    end

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_data = rd_data | cell_tap[i];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (fire)
        begin
            out_valid_next      = 1'b1;
            res_next            = res;
            res_next.read_value = rd_en ? VAL_W'(rd_data) : '0;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.read_value  = res_reg.read_value;
    assign result_out.list_length = res_reg.list_length;
    assign result_out.capacity    = res_reg.capacity;
    assign result_out.status      = res_reg.status;
    assign result_out.has_more    = res_reg.has_more;
    assign result_out.next_index  = res_reg.next_index;

    a_fire_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg
    ) else $error("accepted item produced no result");

    a_error_keeps_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && res.status != ST_OK) |=> cur_len == $past(cur_len)
    ) else $error("failed action changed the length");

    a_capacity_covers_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.capacity >= res_reg.list_length
                           && res_reg.list_length <= LEN_FW'(DEPTH))
    ) else $error("capacity below length or length beyond depth");

endmodule

`default_nettype wire

/* hdl/ilws_cell.sv */
// One storage cell of the list row: holds one element, loads, takes from
// either neighbor, and taps its value for a read. Depends on ilws_pkg.
`default_nettype none

module ilws_cell (
    input  wire logic                            clk,
    input  wire ilws_pkg::cell_ctl_t             ctl,
    input  wire logic [ilws_pkg::CMP_W-1:0]      my_pos,
    input  wire logic [ilws_pkg::CMP_W-1:0]      rd_pos,
    input  wire logic [ilws_pkg::CELL_WIDTH-1:0] left_val,
    input  wire logic [ilws_pkg::CELL_WIDTH-1:0] right_val,
    output      logic [ilws_pkg::CELL_WIDTH-1:0] val,
    output      logic [ilws_pkg::CELL_WIDTH-1:0] tap
);
    import ilws_pkg::*;

    logic [CELL_WIDTH-1:0] val_reg;
    logic [CELL_WIDTH-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.cmd)
            CELL_HOLD:
            begin
                val_next = val_reg;
            end
            CELL_WRITE:
            begin
                if (my_pos == ctl.pos)
                begin
                    val_next = ctl.data;
                end
            end
            CELL_INSERT:
            begin
                if (my_pos == ctl.pos)
                begin
                    val_next = ctl.data;
                end
                else if (my_pos > ctl.pos)
                begin
                    val_next = left_val;
                end
            end
            CELL_DELETE:
            begin
                if (my_pos >= ctl.pos)
                begin
                    val_next = right_val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign tap = (my_pos == rd_pos) ? val_reg : '0;

endmodule

`default_nettype wire

/* hdl/ilws_ctrl.sv */
// List control: length and capacity registers, bounds and fullness checks,
// cell row command and result fields. Depends on ilws_pkg.
`default_nettype none

module ilws_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [ilws_pkg::ACT_W-1:0]   action,
    input  wire logic [ilws_pkg::IDX_FW-1:0]  index,
    input  wire logic [ilws_pkg::VAL_W-1:0]   value,
    output      ilws_pkg::cell_ctl_t          ctl,
    output      ilws_pkg::result_t            res,
    output      logic                         rd_en,
    output      logic [ilws_pkg::CNT_W-1:0]   cur_len
);
    import ilws_pkg::*;

    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] len_x;
    logic [CMP_W-1:0] idx_inc;
    logic             full;
    status_t          status;
    logic             more;
    logic [CMP_W-1:0] nxt;
    cell_cmd_t        cmd;

    assign idx_x   = CMP_W'(index);
    assign len_x   = CMP_W'(len_reg);
    assign idx_inc = idx_x + CMP_W'(1);
    assign full    = len_x >= CMP_W'(DEPTH);

    always_comb
    begin
        len_next = len_reg;
        cap_next = cap_reg;
        status   = ST_OK;
        more     = 1'b0;
        nxt      = '0;
        rd_en    = 1'b0;
        cmd      = CELL_HOLD;
        ctl.pos  = idx_x;
        unique case (action_t'(action))
            ACT_GET:
            begin
                if (idx_x >= len_x)
                begin
                    status = ST_BOUNDS;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            ACT_SET:
            begin
                if (idx_x >= len_x)
                begin
                    status = ST_BOUNDS;
                end
                else
                begin
                    cmd = CELL_WRITE;
                end
            end
            ACT_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd      = CELL_WRITE;
                    ctl.pos  = len_x;
                    len_next = len_reg + CNT_W'(1);
                    cap_next = CNT_W'(grow_cap(WK_W'(cap_reg),
                                               WK_W'(len_reg) + WK_W'(1)));
                end
            end
            ACT_INSERT:
            begin
                if (idx_x > len_x)
                begin
                    status = ST_BOUNDS;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd      = CELL_INSERT;
                    len_next = len_reg + CNT_W'(1);
                    cap_next = CNT_W'(grow_cap(WK_W'(cap_reg),
                                               WK_W'(len_reg) + WK_W'(1)));
                end
            end
            ACT_DELETE:
            begin
                if (idx_x >= len_x)
                begin
                    status = ST_BOUNDS;
                end
                else
                begin
                    cmd      = CELL_DELETE;
                    len_next = len_reg - CNT_W'(1);
                    cap_next = CNT_W'(shrink_cap(WK_W'(cap_reg),
                                                 WK_W'(len_reg) - WK_W'(1)));
                end
            end
            ACT_CLEAR:
            begin
                len_next = '0;
                cap_next = '0;
            end
            ACT_STEP:
            begin
                if (idx_x < len_x)
                begin
                    more = 1'b1;
                    nxt  = idx_inc;
                end
                else
                begin
                    nxt = idx_x;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        ctl.cmd  = fire ? cmd : CELL_HOLD;
        ctl.data = value[CELL_WIDTH-1:0];
    end

    always_comb
    begin
        res.read_value  = '0;
        res.list_length = LEN_FW'(len_next);
        res.capacity    = LEN_FW'(cap_next);
        res.status      = status;
        res.has_more    = more;
        res.next_index  = nxt[IDX_FW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            cap_reg <= '0;
        end
        else if (fire)
        begin
            len_reg <= len_next;
            cap_reg <= cap_next;
        end
    end

    assign cur_len = len_reg;

endmodule

`default_nettype wire
